FILE: design/assert_macros.svh
// Assertion macros for the checker module of the MD4 hasher.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge and switched off during reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("md4 hasher assertion failed");

// Assertion sampled on the rising clock edge, also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("md4 hasher assertion failed");

`endif

FILE: design/md4sh_pkg.sv
// Package of the MD4 stream hasher: widths, initial values, round tables
// and the microcode program. No dependencies.
package md4sh_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIGEST_W = 64;
    localparam int unsigned COUNT_W  = 64;
    localparam int unsigned NWORDS   = 16;
    localparam int unsigned NROUNDS  = 48;

    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
    localparam logic [WORD_W-1:0] K2   = 32'h5A827999;
    localparam logic [WORD_W-1:0] K3   = 32'h6ED9EBA1;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

    localparam logic [3:0] MSG_IDX [NROUNDS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
        4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
        4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
    };
    localparam logic [4:0] ROT_AMT [NROUNDS] = '{
        5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
        5'd3, 5'd7, 5'd11, 5'd19, 5'd3, 5'd7, 5'd11, 5'd19,
        5'd3, 5'd5, 5'd9, 5'd13, 5'd3, 5'd5, 5'd9, 5'd13,
        5'd3, 5'd5, 5'd9, 5'd13, 5'd3, 5'd5, 5'd9, 5'd13,
        5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15,
        5'd3, 5'd9, 5'd11, 5'd15, 5'd3, 5'd9, 5'd11, 5'd15
    };

    localparam logic [2:0] OP_WAIT  = 3'd0;
    localparam logic [2:0] OP_ROUND = 3'd1;
    localparam logic [2:0] OP_FOLD  = 3'd2;
    localparam logic [2:0] OP_PAD   = 3'd3;
    localparam logic [2:0] OP_LEN   = 3'd4;
    localparam logic [2:0] OP_EMIT  = 3'd5;

    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;

    localparam int unsigned PC_W = 6;
    localparam logic [PC_W-1:0] PC_WAIT   = 6'd0;
    localparam logic [PC_W-1:0] PC_ROUND0 = 6'd1;
    localparam logic [PC_W-1:0] PC_RLAST  = 6'd48;
    localparam logic [PC_W-1:0] PC_FOLD   = 6'd49;
    localparam logic [PC_W-1:0] PC_PAD    = 6'd50;
    localparam logic [PC_W-1:0] PC_LEN    = 6'd51;
    localparam logic [PC_W-1:0] PC_EMIT   = 6'd52;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] grp;
        logic [3:0] midx;
        logic [4:0] rot;
    } t_uword;

    // The control store: one word for each program step.
    function automatic t_uword f_uword(input logic [PC_W-1:0] pc);
        t_uword     w;
        logic [5:0] idx;
        w   = '{op: OP_WAIT, grp: GRP_F, midx: 4'd0, rot: 5'd0};
        idx = pc - PC_ROUND0;
        if (pc >= PC_ROUND0 && pc <= PC_RLAST) begin
            w.op   = OP_ROUND;
            w.grp  = idx[5:4];
            w.midx = MSG_IDX[idx];
            w.rot  = ROT_AMT[idx];
        end else if (pc == PC_FOLD) begin
            w.op = OP_FOLD;
        end else if (pc == PC_PAD) begin
            w.op = OP_PAD;
        end else if (pc == PC_LEN) begin
            w.op = OP_LEN;
        end else if (pc == PC_EMIT) begin
            w.op = OP_EMIT;
        end
        return w;
    endfunction

endpackage

FILE: design/md4sh_if.sv
// Request channel interfaces of the MD4 stream hasher: message bytes in,
// digests out. Depends on md4sh_pkg.
interface md4sh_byte_if
    import md4sh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] message_byte;
    logic              byte_present;
    logic              end_of_message;

    modport source(output valid, output message_byte, output byte_present,
                   output end_of_message, input ready);
    modport sink(input valid, input message_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

interface md4sh_digest_if
    import md4sh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DIGEST_W-1:0] digest_low;
    logic [DIGEST_W-1:0] digest_high;

    modport source(output valid, output digest_low, output digest_high, input ready);
    modport sink(input valid, input digest_low, input digest_high, output ready);
endinterface

FILE: design/md4_stream_hasher_unit.sv
// MD4 stream hasher top level: microcoded sequencer and datapath.
// Depends on md4sh_pkg and the channel interfaces in md4sh_if.sv.
//
// Usage: i_req carries one request per message byte (byte_present) and may
// mark the end of the message (end_of_message); a request with neither flag
// has no effect. o_dig delivers one digest request per finished message.
// A byte that does not complete a 64-byte block is stored in the block buffer.
// The byte that completes a block is followed by the 48 compression rounds
// and one fold step, during which no byte is taken; the single round unit,
// one round per cycle, sets the byte throughput.
// After an end request: one padding step, a compression of the padded block
// when 8 or fewer bytes remain in it, one length step, the final compression
// and one emit step, with one more compression first when the end request
// also completes a block.
// Reset loads the initial chaining words, clears the byte count and empties
// the output register. A stalled receiver holds the digest in the output
// register; bytes of the next message are still taken, and only the next
// emit step waits for the register to drain.
module md4_stream_hasher_unit
    import md4sh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    md4sh_byte_if.sink    i_req,
    md4sh_digest_if.source o_dig
);

    localparam logic [1:0] CTX_BYTE     = 2'd0;
    localparam logic [1:0] CTX_BYTE_END = 2'd1;
    localparam logic [1:0] CTX_PAD      = 2'd2;
    localparam logic [1:0] CTX_FINAL    = 2'd3;

    logic [PC_W-1:0]     r_pc;
    logic [1:0]          r_ctx;
    logic [WORD_W-1:0]   r_chain [4];
    logic [WORD_W-1:0]   r_blk [NWORDS];
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d;
    logic [COUNT_W-1:0]  r_count;
    logic                r_out_valid;
    logic [DIGEST_W-1:0] r_dig_low, r_dig_high;

    t_uword            uw;
    logic [5:0]        used;
    logic [3:0]        widx;
    logic [1:0]        lane;
    logic [WORD_W-1:0] f_val, k_val, sum, rot_val;
    logic [WORD_W-1:0] n_byte_word, n_pad_word;
    logic [PC_W-1:0]   n_pc;

    always_comb begin
        uw   = f_uword(r_pc);
        used = r_count[5:0];
        widx = used[5:2];
        lane = used[1:0];
        case (uw.grp)
            GRP_F: begin
                f_val = (r_b & r_c) | (~r_b & r_d);
                k_val = '0;
            end
            GRP_G: begin
                f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                k_val = K2;
            end
            default: begin
                f_val = r_b ^ r_c ^ r_d;
                k_val = K3;
            end
        endcase
        sum     = r_a + f_val + r_blk[uw.midx] + k_val;
        rot_val = (sum << uw.rot) | (sum >> (6'd32 - {1'b0, uw.rot}));
        n_byte_word = ((lane == 2'd0) ? '0 : r_blk[widx])
                    | (WORD_W'(i_req.message_byte) << {lane, 3'b000});
        n_pad_word  = ((lane == 2'd0) ? '0 : r_blk[widx])
                    | (WORD_W'(PAD_BYTE) << {lane, 3'b000});
        n_pc = r_pc + 1'b1;
    end

    assign i_req.ready       = (uw.op == OP_WAIT);
    assign o_dig.valid       = r_out_valid;
    assign o_dig.digest_low  = r_dig_low;
    assign o_dig.digest_high = r_dig_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_ctx       <= CTX_BYTE;
            r_chain[0]  <= IV_A;
            r_chain[1]  <= IV_B;
            r_chain[2]  <= IV_C;
            r_chain[3]  <= IV_D;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_dig.ready && uw.op != OP_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (uw.op)
                OP_WAIT: begin
                    if (i_req.valid) begin
                        if (i_req.byte_present) begin
                            r_blk[widx] <= n_byte_word;
                            r_count     <= r_count + 1'b1;
                        end
                        if (i_req.byte_present && used == 6'd63) begin
                            r_a   <= r_chain[0];
                            r_b   <= r_chain[1];
                            r_c   <= r_chain[2];
                            r_d   <= r_chain[3];
                            r_ctx <= i_req.end_of_message ? CTX_BYTE_END : CTX_BYTE;
                            r_pc  <= PC_ROUND0;
                        end else if (i_req.end_of_message) begin
                            r_ctx <= CTX_BYTE;
                            r_pc  <= PC_PAD;
                        end
                    end
                end
                OP_ROUND: begin
                    r_a  <= r_d;
                    r_b  <= rot_val;
                    r_c  <= r_b;
                    r_d  <= r_c;
                    r_pc <= n_pc;
                end
                OP_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    case (r_ctx)
                        CTX_BYTE:     r_pc <= PC_WAIT;
                        CTX_BYTE_END: r_pc <= PC_PAD;
                        CTX_PAD:      r_pc <= PC_LEN;
                        default:      r_pc <= PC_EMIT;
                    endcase
                end
                OP_PAD: begin
                    for (int i = 0; i < NWORDS; i++) begin
                        if (4'(i) > widx) begin
                            r_blk[i] <= '0;
                        end
                    end
                    r_blk[widx] <= n_pad_word;
                    if (used[5:3] == 3'd7) begin
                        r_a   <= r_chain[0];
                        r_b   <= r_chain[1];
                        r_c   <= r_chain[2];
                        r_d   <= r_chain[3];
                        r_ctx <= CTX_PAD;
                        r_pc  <= PC_ROUND0;
                    end else begin
                        r_ctx <= CTX_BYTE;
                        r_pc  <= PC_LEN;
                    end
                end
                OP_LEN: begin
                    if (r_ctx == CTX_PAD) begin
                        for (int i = 0; i < NWORDS - 2; i++) begin
                            r_blk[i] <= '0;
                        end
                    end
                    r_blk[NWORDS-2] <= {r_count[28:0], 3'b000};
                    r_blk[NWORDS-1] <= r_count[60:29];
                    r_a   <= r_chain[0];
                    r_b   <= r_chain[1];
                    r_c   <= r_chain[2];
                    r_d   <= r_chain[3];
                    r_ctx <= CTX_FINAL;
                    r_pc  <= PC_ROUND0;
                end
                OP_EMIT: begin
                    if (!r_out_valid || o_dig.ready) begin
                        r_out_valid <= 1'b1;
                        r_dig_low   <= {r_chain[1], r_chain[0]};
                        r_dig_high  <= {r_chain[3], r_chain[2]};
                        r_chain[0]  <= IV_A;
                        r_chain[1]  <= IV_B;
                        r_chain[2]  <= IV_C;
                        r_chain[3]  <= IV_D;
                        r_count     <= '0;
                        r_pc        <= PC_WAIT;
                    end
                end
                default: begin
                    r_pc <= PC_WAIT;
                end
            endcase
        end
    end

endmodule

FILE: design/md4sh_checker.sv
// Port checker for md4_stream_hasher_unit, attached by bind.
// Depends on md4sh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module md4sh_checker
    import md4sh_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_req_end,
    input logic                i_dig_valid,
    input logic                i_dig_ready,
    input logic [DIGEST_W-1:0] i_dig_low,
    input logic [DIGEST_W-1:0] i_dig_high
);

    // The output register is empty on the first cycle after reset.
    `ASSERT_RST(a_empty_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> !i_dig_valid)

    // A stalled digest request keeps its value.
    `ASSERT_RST(a_digest_holds, i_clk, i_rst_n, (i_dig_valid && !i_dig_ready) |=> (i_dig_valid && $stable(i_dig_low) && $stable(i_dig_high)))

    // A new digest only comes out of the emit step, during which no byte is taken.
    `ASSERT_RST(a_emit_blocks_input, i_clk, i_rst_n, $rose(i_dig_valid) |-> $past(!i_req_ready))

    // Ending a message always starts the finishing sequence.
    `ASSERT_RST(a_end_goes_busy, i_clk, i_rst_n, (i_req_valid && i_req_ready && i_req_end) |=> !i_req_ready)

endmodule

bind md4_stream_hasher_unit md4sh_checker u_md4sh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_end   (i_req.end_of_message),
    .i_dig_valid (o_dig.valid),
    .i_dig_ready (o_dig.ready),
    .i_dig_low   (o_dig.digest_low),
    .i_dig_high  (o_dig.digest_high)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for md4_stream_hasher_unit: drives byte requests,
// predicts each MD4 digest internally and compares every digest request.
// Depends on md4sh_pkg, the channel interfaces and the hasher top level.
module tb;
    import md4sh_pkg::*;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C   = 32'h98BADCFE;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [31:0] ROUND2_K = 32'h5A827999;
    localparam logic [31:0] ROUND3_K = 32'h6ED9EBA1;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam int ROT_TAB [3][4] = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};

    localparam int unsigned RANDOM_REQUESTS = 1100;
    localparam int unsigned IDLE_PERCENT = 12;
    localparam int unsigned HOLD_OFF_CYCLES = 1500;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } t_md4_digest;

    logic i_clk = 1'b0;
    logic i_rst_n;

    md4sh_byte_if   req_if ();
    md4sh_digest_if dig_if ();

    md4_stream_hasher_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_dig  (dig_if)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] chain_q [4];
    logic [31:0] block_q [16];
    logic [63:0] byte_total;

    t_md4_digest pending_digests [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned requests_sent = 0;
    int unsigned hold_request = 0;
    bit          steady_flow = 1'b0;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void restart_chain();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        byte_total = '0;
    endfunction

    function automatic void md4_compress();
        logic [31:0] a, b, c, d, f, k, t;
        int unsigned rnd, grp, j, w;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (rnd = 0; rnd < 48; rnd++) begin
            grp = rnd / 16;
            j = rnd % 16;
            case (grp)
                0: begin
                    f = (b & c) | (~b & d);
                    k = '0;
                    w = j;
                end
                1: begin
                    f = (b & c) | (b & d) | (c & d);
                    k = ROUND2_K;
                    w = (j % 4) * 4 + j / 4;
                end
                default: begin
                    f = b ^ c ^ d;
                    k = ROUND3_K;
                    w = 32'({j[0], j[1], j[2], j[3]});
                end
            endcase
            t = rotl32(a + f + block_q[w] + k, ROT_TAB[grp][j % 4]);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
    endfunction

    function automatic void store_byte(input int unsigned pos, input logic [7:0] v);
        int unsigned w, sh;
        w = (pos >> 2) & 15;
        sh = (pos & 3) * 8;
        if ((pos & 3) == 0)
            block_q[w] = '0;
        block_q[w][sh +: 8] = v;
    endfunction

    function automatic t_md4_digest finish_message();
        int unsigned used, w;
        logic [63:0] bit_len;
        t_md4_digest dig;
        used = 32'(byte_total[5:0]);
        store_byte(used, PAD_MARK);
        for (w = (used >> 2) + 1; w < 16; w++)
            block_q[w] = '0;
        if (used >= 56) begin
            md4_compress();
            for (w = 0; w < 14; w++)
                block_q[w] = '0;
        end
        bit_len = byte_total << 3;
        block_q[14] = bit_len[31:0];
        block_q[15] = bit_len[63:32];
        md4_compress();
        dig.low = {chain_q[1], chain_q[0]};
        dig.high = {chain_q[3], chain_q[2]};
        restart_chain();
        return dig;
    endfunction

    function automatic void md4_absorb_request(input logic [7:0] b, input logic present,
                                               input logic eom);
        int unsigned used;
        if (present) begin
            used = 32'(byte_total[5:0]);
            store_byte(used, b);
            byte_total += 1;
            if (used == 63)
                md4_compress();
        end
        if (eom)
            pending_digests.push_back(finish_message());
    endfunction

    always @(posedge i_clk) begin
        t_md4_digest want;
        bit moved;
        if (!i_rst_n) begin
            for (int w = 0; w < 16; w++)
                block_q[w] = '0;
            restart_chain();
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                md4_absorb_request(req_if.message_byte, req_if.byte_present,
                                   req_if.end_of_message);
            end
            if (dig_if.valid && dig_if.ready) begin
                moved = 1'b1;
                if (pending_digests.size() == 0) begin
                    $error("unexpected digest: digest_low %h digest_high %h",
                           dig_if.digest_low, dig_if.digest_high);
                    mismatch_count++;
                end else begin
                    want = pending_digests.pop_front();
                    if (dig_if.digest_low !== want.low) begin
                        $error("digest_low mismatch: expected %h, actual %h",
                               want.low, dig_if.digest_low);
                        mismatch_count++;
                    end
                    if (dig_if.digest_high !== want.high) begin
                        $error("digest_high mismatch: expected %h, actual %h",
                               want.high, dig_if.digest_high);
                        mismatch_count++;
                    end
                end
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    // The receiver normally stalls at random; a hold-off request from a test
    // keeps ready low for the requested number of cycles, counted here.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        dig_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                dig_if.ready <= 1'b0;
            end else if (steady_flow) begin
                dig_if.ready <= 1'b1;
            end else begin
                dig_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.message_byte <= b;
        req_if.byte_present <= present;
        req_if.end_of_message <= eom;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        if (present || eom)
            requests_sent++;
    endtask

    task automatic send_message(input int unsigned len, input bit with_noise);
        bit end_on_byte;
        end_on_byte = (len != 0) && $urandom_range(1);
        for (int unsigned i = 0; i < len; i++) begin
            if (with_noise && $urandom_range(99) < 4)
                send_request(8'($urandom_range(255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
            return 64 * $urandom_range(1) + 55 + $urandom_range(9);
        else if (sel < 40)
            return $urandom_range(3);
        else if (sel < 92)
            return $urandom_range(80);
        else
            return $urandom_range(260, 131);
    endfunction

    task automatic test_empty_message();
        send_request(8'($urandom_range(255)), 1'b0, 1'b1);
        send_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic test_idle_requests();
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b1);
    endtask

    task automatic test_byte_with_end();
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h80, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        for (int n = 0; n < 4; n++)
            send_message(64 * $urandom_range(1) + 55 + $urandom_range(9), 1'b0);
        steady_flow = 1'b0;
    endtask

    task automatic test_digest_backpressure();
        hold_request = HOLD_OFF_CYCLES;
        for (int n = 0; n < 8; n++)
            send_message($urandom_range(8), 1'b0);
    endtask

    task automatic test_random_messages();
        int unsigned start_count;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS)
            send_message(pick_length(), 1'b1);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.message_byte <= '0;
        req_if.byte_present <= 1'b0;
        req_if.end_of_message <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_idle_requests();
        test_byte_with_end();
        test_steady_stream();
        test_digest_backpressure();
        test_random_messages();

        req_if.valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
